FILE: rtl/ahg_pkg.sv
// ----------------------------------------------------------------------------
// ahg_pkg
// shared types, constants and the bar row/code table of the horizon generator
// ----------------------------------------------------------------------------
package ahg_pkg;

  // glyph set
  localparam int SYMBOL_COUNT      = 9;
  localparam logic [7:0] DECORATION_SYMBOL = 8'd19;
  localparam logic [7:0] LEFT_SYMBOL       = 8'd3;
  localparam logic [7:0] RIGHT_SYMBOL      = 8'd2;

  // geometry
  localparam int MAX_GLYPHS   = 36;
  localparam int CNT_W        = $clog2(MAX_GLYPHS);
  localparam int BAR_LANES    = 9;
  localparam int BAR_HALF     = 4;
  localparam int LANE_W       = $clog2(BAR_LANES);
  localparam int BAR_Y_MAX    = 81;
  localparam int BAR_Y_W      = 7;
  localparam int PITCH_SCALE  = 25;
  localparam int PITCH_OFFSET = 4 * SYMBOL_COUNT + 5;
  localparam int ROW_BIAS     = SYMBOL_COUNT / 2;

  // pitch divider: quotient never exceeds the scale factor
  localparam int DIV_STEPS = 5;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int NUM_W     = 12;

  localparam int QUEUE_DEPTH = 2;

  // mode flag bits
  localparam int MODE_INV_PITCH = 0;
  localparam int MODE_INV_ROLL  = 1;
  localparam int MODE_SIDEBARS  = 2;

  typedef enum logic [3:0] {
    CFG_MODE_FLAGS      = 4'd0,
    CFG_MAX_PITCH       = 4'd1,
    CFG_MAX_ROLL        = 4'd2,
    CFG_SIDEBAR_HEIGHT  = 4'd3,
    CFG_SIDEBAR_WIDTH   = 4'd4,
    CFG_CENTER_COL      = 4'd5,
    CFG_CENTER_ROW      = 4'd6,
    CFG_BAR_SYMBOL_BASE = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0] mode_flags;
    logic [6:0] max_pitch;
    logic [6:0] max_roll;
    logic [3:0] sidebar_height;
    logic [3:0] sidebar_width;
    logic [5:0] center_col;
    logic [4:0] center_row;
    logic [7:0] bar_symbol_base;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode_flags:      3'd0,
    max_pitch:       7'd20,
    max_roll:        7'd40,
    sidebar_height:  4'd3,
    sidebar_width:   4'd7,
    center_col:      6'd15,
    center_row:      5'd8,
    bar_symbol_base: 8'd128
  };

  // one classified item as handed from front to back
  typedef struct packed {
    logic [BAR_LANES-1:0]              bar_mask;
    logic [BAR_LANES-1:0][BAR_Y_W-1:0] bar_y;
    logic                              blink;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_BAR,
    B_SIDE
  } back_state_t;

  // bar height -> {row step, sub-position}
  localparam int QUOT_W        = 7;
  localparam int REM_W         = 4;
  localparam int BAR_TBL_DEPTH = 1 << BAR_Y_W;

  typedef logic [BAR_TBL_DEPTH-1:0][QUOT_W+REM_W-1:0] bar_tbl_t;

  function automatic bar_tbl_t build_bar_tbl();
    bar_tbl_t t;
    for (int i = 0; i < BAR_TBL_DEPTH; i++) begin
      t[i] = {QUOT_W'(i / SYMBOL_COUNT), REM_W'(i % SYMBOL_COUNT)};
    end
    return t;
  endfunction

  localparam bar_tbl_t BAR_TBL = build_bar_tbl();

endpackage

FILE: rtl/artificial_horizon_glyph_generator_top.sv
// ----------------------------------------------------------------------------
// artificial_horizon_glyph_generator_top
// attitude word in, stream of horizon line and sidebar glyphs out
// ----------------------------------------------------------------------------
// a word (pitch, roll, blink) is taken when start is high and busy is low and
// is clamped in that same cycle. after that the front holds busy while the
// bit-per-cycle pitch divider (pitch*25/max_pitch) runs and then while it
// classifies the nine bar columns and hands the word to a two-deep queue, so
// the front takes no new word before the last one is handed on. busy stays up
// longer only while that queue is full. the back drains the queue and sends
// glyphs one per cycle, with no gaps inside a run: it loads a word from the
// queue in its idle state, then sends its glyphs, and pops no new word before
// the run is done. the slower of front and back sets the sustained word rate.
// out_valid marks each glyph for exactly one cycle and the receiver must take
// it then; there is no way to hold output off. the final glyph of a run has
// out_last_glyph set. a word that yields no glyph produces nothing on the
// output. registers are written through the cfg channel (cfg_ready is always
// high) and should only change while no word is in flight.
// ----------------------------------------------------------------------------
module artificial_horizon_glyph_generator_top (
  input  logic               clk,
  input  logic               rst_n,

  // attitude words
  input  logic               start,
  output logic               busy,
  input  logic signed [8:0]  in_pitch_deg,
  input  logic signed [8:0]  in_roll_deg,
  input  logic               in_blink_on,

  // glyph stream
  output logic               out_valid,
  output logic signed [7:0]  out_glyph_col,
  output logic signed [6:0]  out_glyph_row,
  output logic [7:0]         out_glyph_code,
  output logic               out_glyph_blink,
  output logic               out_last_glyph,

  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  ahg_pkg::cfg_t cfg_r;

  // front <-> queue <-> back
  ahg_pkg::job_t front_job;
  ahg_pkg::job_t queue_job;
  logic          q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  // register file; indexes past the list are dropped, data is cut to width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ahg_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ahg_pkg::CFG_MODE_FLAGS:      cfg_r.mode_flags      <= cfg_data[2:0];
        ahg_pkg::CFG_MAX_PITCH:       cfg_r.max_pitch       <= cfg_data[6:0];
        ahg_pkg::CFG_MAX_ROLL:        cfg_r.max_roll        <= cfg_data[6:0];
        ahg_pkg::CFG_SIDEBAR_HEIGHT:  cfg_r.sidebar_height  <= cfg_data[3:0];
        ahg_pkg::CFG_SIDEBAR_WIDTH:   cfg_r.sidebar_width   <= cfg_data[3:0];
        ahg_pkg::CFG_CENTER_COL:      cfg_r.center_col      <= cfg_data[5:0];
        ahg_pkg::CFG_CENTER_ROW:      cfg_r.center_row      <= cfg_data[4:0];
        ahg_pkg::CFG_BAR_SYMBOL_BASE: cfg_r.bar_symbol_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp, scale pitch, classify bar columns
  ahg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .pitch_deg (in_pitch_deg),
    .roll_deg  (in_roll_deg),
    .blink_on  (in_blink_on),
    .busy      (busy),
    .q_full    (q_full),
    .push      (q_push),
    .job       (front_job)
  );

  // lets the front take the next word while the back is still sending
  ahg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (front_job),
    .pop   (q_pop),
    .dout  (queue_job),
    .full  (q_full),
    .empty (q_empty)
  );

  // glyph sequencer: bars, then sidebars and markers
  ahg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_dout          (queue_job),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_glyph_col   (out_glyph_col),
    .out_glyph_row   (out_glyph_row),
    .out_glyph_code  (out_glyph_code),
    .out_glyph_blink (out_glyph_blink),
    .out_last_glyph  (out_last_glyph)
  );

endmodule

FILE: rtl/ahg_front.sv
// ----------------------------------------------------------------------------
// ahg_front
// takes an attitude word, clamps, scales pitch and classifies the bar columns
// ----------------------------------------------------------------------------
module ahg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  ahg_pkg::cfg_t       cfg,
  input  logic                start,
  input  logic signed [8:0]   pitch_deg,
  input  logic signed [8:0]   roll_deg,
  input  logic                blink_on,
  output logic                busy,
  input  logic                q_full,
  output logic                push,
  output ahg_pkg::job_t       job
);

  ahg_pkg::front_state_t state_r, state_nxt;

  logic [ahg_pkg::NUM_W-1:0]     rem_r;
  logic [ahg_pkg::DIV_STEPS-1:0] quot_r;
  logic [ahg_pkg::STEP_W-1:0]    step_r;
  logic                          neg_r;
  logic signed [7:0]             roll_r;
  logic                          blink_r;

  // accept path: invert, clamp, magnitude times scale
  logic signed [9:0]         p_raw, p_inv, p_lim, p_cl;
  logic signed [9:0]         r_raw, r_inv, r_lim, r_cl;
  logic [6:0]                p_mag;
  logic [ahg_pkg::NUM_W-1:0] num;

  always_comb begin
    p_raw = 10'(pitch_deg);
    p_inv = cfg.mode_flags[ahg_pkg::MODE_INV_PITCH] ? -p_raw : p_raw;
    p_lim = $signed({3'b000, cfg.max_pitch});
    if (p_inv > p_lim) begin
      p_cl = p_lim;
    end else if (p_inv < -p_lim) begin
      p_cl = -p_lim;
    end else begin
      p_cl = p_inv;
    end
    p_mag = p_cl[9] ? 7'(-p_cl) : 7'(p_cl);
    num   = ahg_pkg::NUM_W'(p_mag) * ahg_pkg::NUM_W'(ahg_pkg::PITCH_SCALE);

    r_raw = 10'(roll_deg);
    r_inv = cfg.mode_flags[ahg_pkg::MODE_INV_ROLL] ? -r_raw : r_raw;
    r_lim = $signed({3'b000, cfg.max_roll});
    if (r_inv > r_lim) begin
      r_cl = r_lim;
    end else if (r_inv < -r_lim) begin
      r_cl = -r_lim;
    end else begin
      r_cl = r_inv;
    end
  end

  // one restoring step per cycle
  logic [ahg_pkg::NUM_W-1:0] div_shift;
  logic                      div_fits;

  assign div_shift = ahg_pkg::NUM_W'(cfg.max_pitch) << step_r;
  assign div_fits  = (cfg.max_pitch != '0) && (rem_r >= div_shift);

  // bar lanes: y = trunc(-roll*x/8) + offset - scaled pitch
  logic signed [6:0]  q_s;
  logic signed [9:0]  y_base;
  logic signed [10:0] roll_ext;
  logic signed [10:0] fac  [ahg_pkg::BAR_LANES];
  logic signed [10:0] prod [ahg_pkg::BAR_LANES];
  logic signed [10:0] tr   [ahg_pkg::BAR_LANES];
  logic signed [9:0]  y    [ahg_pkg::BAR_LANES];

  always_comb begin
    q_s      = neg_r ? -$signed({2'b00, quot_r}) : $signed({2'b00, quot_r});
    y_base   = 10'(ahg_pkg::PITCH_OFFSET) - 10'(q_s);
    roll_ext = 11'(roll_r);
    job.blink = blink_r;
    for (int i = 0; i < ahg_pkg::BAR_LANES; i++) begin
      fac[i]  = $signed(11'(ahg_pkg::BAR_HALF - i));
      prod[i] = roll_ext * fac[i];
      tr[i]   = prod[i][10] ? -((-prod[i]) >>> 3) : (prod[i] >>> 3);
      y[i]    = 10'(tr[i]) + y_base;
      job.bar_mask[i] = !y[i][9] && (y[i] <= 10'(ahg_pkg::BAR_Y_MAX));
      job.bar_y[i]    = y[i][ahg_pkg::BAR_Y_W-1:0];
    end
  end

  always_comb begin : front_next
    state_nxt = state_r;
    case (state_r)
      ahg_pkg::F_IDLE: if (start) state_nxt = ahg_pkg::F_DIV;
      ahg_pkg::F_DIV:  if (step_r == '0) state_nxt = ahg_pkg::F_PUSH;
      ahg_pkg::F_PUSH: if (!q_full) state_nxt = ahg_pkg::F_IDLE;
      default:         state_nxt = ahg_pkg::F_IDLE;
    endcase
  end

  always_comb begin : front_out
    busy = (state_r != ahg_pkg::F_IDLE);
    push = (state_r == ahg_pkg::F_PUSH) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ahg_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ahg_pkg::F_IDLE && start) begin
      rem_r   <= num;
      quot_r  <= '0;
      step_r  <= ahg_pkg::STEP_W'(ahg_pkg::DIV_STEPS - 1);
      neg_r   <= p_cl[9];
      roll_r  <= 8'(r_cl);
      blink_r <= blink_on;
    end else if (state_r == ahg_pkg::F_DIV) begin
      if (div_fits) begin
        rem_r  <= rem_r - div_shift;
        quot_r <= quot_r | (ahg_pkg::DIV_STEPS'(1) << step_r);
      end
      step_r <= step_r - 1'b1;
    end
  end

endmodule

FILE: rtl/ahg_queue.sv
// ----------------------------------------------------------------------------
// ahg_queue
// short first-in first-out buffer of classified words between front and back
// ----------------------------------------------------------------------------
module ahg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ahg_pkg::job_t din,
  input  logic          pop,
  output ahg_pkg::job_t dout,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(ahg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ahg_pkg::QUEUE_DEPTH + 1);

  ahg_pkg::job_t     mem_r [ahg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full  = (cnt_r == CNT_W'(ahg_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(ahg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(ahg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

FILE: rtl/ahg_back.sv
// ----------------------------------------------------------------------------
// ahg_back
// walks one classified word and sends its glyphs, one per cycle
// ----------------------------------------------------------------------------
module ahg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ahg_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  ahg_pkg::job_t      q_dout,
  output logic               pop,
  output logic               out_valid,
  output logic signed [7:0]  out_glyph_col,
  output logic signed [6:0]  out_glyph_row,
  output logic [7:0]         out_glyph_code,
  output logic               out_glyph_blink,
  output logic               out_last_glyph
);

  ahg_pkg::back_state_t state_r, state_nxt;

  logic [ahg_pkg::BAR_LANES-1:0]                      mask_r;
  logic [ahg_pkg::BAR_LANES-1:0][ahg_pkg::BAR_Y_W-1:0] bar_y_r;
  logic                                               blink_r;
  logic [ahg_pkg::CNT_W-1:0]                          cnt_r;
  logic signed [4:0]                                  dy_r;
  logic                                               side_r;
  logic                                               mark_r;

  logic                 out_valid_r, out_last_r, out_blink_r;
  logic signed [7:0]    out_col_r;
  logic signed [6:0]    out_row_r;
  logic [7:0]           out_code_r;

  logic                                     side_en;
  logic                                     emit, last, run_end;
  logic [ahg_pkg::LANE_W-1:0]               lane;
  logic [ahg_pkg::BAR_LANES-1:0]            mask_clr;
  logic [ahg_pkg::BAR_Y_W-1:0]              y_sel;
  logic [ahg_pkg::QUOT_W+ahg_pkg::REM_W-1:0] tbl_ent;
  logic [7:0]                               col;
  logic [6:0]                               row;
  logic [7:0]                               code;

  assign side_en = cfg.mode_flags[ahg_pkg::MODE_SIDEBARS];

  always_comb begin : emit_logic
    lane = '0;
    for (int i = ahg_pkg::BAR_LANES - 1; i >= 0; i--) begin
      if (mask_r[i]) lane = ahg_pkg::LANE_W'(i);
    end
    y_sel   = bar_y_r[lane];
    tbl_ent = ahg_pkg::BAR_TBL[y_sel];

    pop      = (state_r == ahg_pkg::B_IDLE) && !q_empty;
    emit     = 1'b0;
    run_end  = 1'b0;
    mask_clr = mask_r;
    col      = '0;
    row      = '0;
    code     = '0;
    case (state_r)
      ahg_pkg::B_BAR: begin
        emit     = 1'b1;
        mask_clr = mask_r & ~(ahg_pkg::BAR_LANES'(1) << lane);
        run_end  = (mask_clr == '0) && !side_en;
        col  = 8'(cfg.center_col) + 8'(lane) - 8'(ahg_pkg::BAR_HALF);
        row  = 7'(cfg.center_row) + tbl_ent[ahg_pkg::QUOT_W+ahg_pkg::REM_W-1:ahg_pkg::REM_W]
               - 7'(ahg_pkg::ROW_BIAS);
        code = cfg.bar_symbol_base + 8'(tbl_ent[ahg_pkg::REM_W-1:0]);
      end
      ahg_pkg::B_SIDE: begin
        emit    = 1'b1;
        run_end = mark_r && side_r;
        if (!mark_r) begin
          col  = side_r ? 8'(cfg.center_col) + 8'(cfg.sidebar_width)
                        : 8'(cfg.center_col) - 8'(cfg.sidebar_width);
          row  = 7'(cfg.center_row) + 7'(dy_r);
          code = ahg_pkg::DECORATION_SYMBOL;
        end else begin
          col  = side_r ? 8'(cfg.center_col) + 8'(cfg.sidebar_width) - 8'd1
                        : 8'(cfg.center_col) - 8'(cfg.sidebar_width) + 8'd1;
          row  = 7'(cfg.center_row);
          code = side_r ? ahg_pkg::RIGHT_SYMBOL : ahg_pkg::LEFT_SYMBOL;
        end
      end
      default: ;
    endcase
    // cap at the glyph budget
    last = emit && (run_end || (cnt_r == ahg_pkg::CNT_W'(ahg_pkg::MAX_GLYPHS - 1)));
  end

  always_comb begin : back_next
    state_nxt = state_r;
    case (state_r)
      ahg_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (q_dout.bar_mask != '0) begin
            state_nxt = ahg_pkg::B_BAR;
          end else if (side_en) begin
            state_nxt = ahg_pkg::B_SIDE;
          end
        end
      end
      ahg_pkg::B_BAR: begin
        if (last) begin
          state_nxt = ahg_pkg::B_IDLE;
        end else if (mask_clr == '0) begin
          state_nxt = ahg_pkg::B_SIDE;
        end
      end
      ahg_pkg::B_SIDE: if (last) state_nxt = ahg_pkg::B_IDLE;
      default: state_nxt = ahg_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ahg_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      out_last_r  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mask_r  <= q_dout.bar_mask;
      bar_y_r <= q_dout.bar_y;
      blink_r <= q_dout.blink;
      cnt_r   <= '0;
      dy_r    <= 5'sd0 - $signed({1'b0, cfg.sidebar_height});
      side_r  <= 1'b0;
      mark_r  <= 1'b0;
    end else if (emit) begin
      cnt_r  <= cnt_r + 1'b1;
      mask_r <= mask_clr;
      if (state_r == ahg_pkg::B_SIDE) begin
        if (!side_r) begin
          side_r <= 1'b1;
        end else if (!mark_r) begin
          side_r <= 1'b0;
          if (dy_r == $signed({1'b0, cfg.sidebar_height})) begin
            mark_r <= 1'b1;
          end else begin
            dy_r <= dy_r + 5'sd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_col_r   <= col;
      out_row_r   <= row;
      out_code_r  <= code;
      out_blink_r <= blink_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_last_glyph  = out_last_r;
  assign out_glyph_col   = out_col_r;
  assign out_glyph_row   = out_row_r;
  assign out_glyph_code  = out_code_r;
  assign out_glyph_blink = out_blink_r;

endmodule

FILE: rtl/ahg_checker.sv
// ----------------------------------------------------------------------------
// ahg_checker
// port-level checks on the horizon glyph generator
// ----------------------------------------------------------------------------
module ahg_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last_glyph
);

  // reset leaves nothing in flight
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("output or busy active after reset");

  // a taken word occupies the front for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("front not busy after taking a word");

  // glyphs of one run come without gaps
  a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_glyph |=> out_valid)
    else $error("gap inside a glyph run");

  // end-of-run flag only rides on a glyph
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_glyph |-> out_valid)
    else $error("last flag without a glyph");

endmodule

bind artificial_horizon_glyph_generator_top ahg_checker u_ahg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_last_glyph (out_last_glyph)
);

FILE: sim/artificial_horizon_glyph_generator_top_test.sv
// ----------------------------------------------------------------------------
// artificial_horizon_glyph_generator_top_test
// self-checking bench: attitude words in, predicted horizon glyphs compared
// ----------------------------------------------------------------------------
// every accepted attitude word is run through a local model of the horizon
// line and sidebar layout, and the glyphs it should produce are queued. a
// checker compares each strobed glyph, field by field, with the oldest queued
// one. directed tests cover reset settings, sign inversion, the widest and
// the zero limits, raw values beyond the stated ranges and the glyph cap;
// random phases follow, each with its own register setting.
// ----------------------------------------------------------------------------
module artificial_horizon_glyph_generator_top_test;

  // layout constants of the horizon line
  localparam int GLYPH_LIMIT   = 36;
  localparam int PITCH_SPAN    = 25;
  localparam int BAR_TOP       = 81;
  localparam int BAR_LIFT      = 4 * ahg_pkg::SYMBOL_COUNT + 5;
  // margin for the front, the back and the two words the queue can hold
  localparam int SETTLE_CYCLES = 128;
  // first register index that the block ignores
  localparam int CFG_STRAY_LO  = ahg_pkg::CFG_BAR_SYMBOL_BASE + 1;
  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 26;

  typedef struct packed {
    logic [7:0] col;
    logic [6:0] row;
    logic [7:0] code;
    logic       blink;
    logic       last;
  } glyph_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic signed [8:0] in_pitch_deg = '0;
  logic signed [8:0] in_roll_deg = '0;
  logic              in_blink_on = 1'b0;
  logic              out_valid;
  logic signed [7:0] out_glyph_col;
  logic signed [6:0] out_glyph_row;
  logic [7:0]        out_glyph_code;
  logic              out_glyph_blink;
  logic              out_last_glyph;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [3:0]        cfg_index = '0;
  logic [7:0]        cfg_data = '0;

  // local copy of the register file, updated on each write handshake
  ahg_pkg::cfg_t reg_model = ahg_pkg::CFG_RESET;
  glyph_t        expected_glyphs[$];
  int            glyph_errors = 0;
  bit            idle_enable = 1'b1;

  artificial_horizon_glyph_generator_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pitch_deg    (in_pitch_deg),
    .in_roll_deg     (in_roll_deg),
    .in_blink_on     (in_blink_on),
    .out_valid       (out_valid),
    .out_glyph_col   (out_glyph_col),
    .out_glyph_row   (out_glyph_row),
    .out_glyph_code  (out_glyph_code),
    .out_glyph_blink (out_glyph_blink),
    .out_last_glyph  (out_last_glyph),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  // safety net against a hung handshake or glyphs that never come
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // glyphs of one attitude word, in output order, capped at the glyph limit
  function automatic void predict_glyphs(logic [8:0] pitch_raw, logic [8:0] roll_raw,
                                         logic blink);
    glyph_t run [0:79];
    int     n;
    int     pitch, roll, lim_p, lim_r;
    int     cc, cr, h, w, x, y, cap, i;
    n     = 0;
    pitch = $signed(pitch_raw);
    roll  = $signed(roll_raw);
    lim_p = reg_model.max_pitch;
    lim_r = reg_model.max_roll;
    cc    = reg_model.center_col;
    cr    = reg_model.center_row;
    h     = reg_model.sidebar_height;
    w     = reg_model.sidebar_width;

    if (reg_model.mode_flags[ahg_pkg::MODE_INV_PITCH]) pitch = -pitch;
    if (reg_model.mode_flags[ahg_pkg::MODE_INV_ROLL]) roll = -roll;
    if (pitch > lim_p) pitch = lim_p;
    else if (pitch < -lim_p) pitch = -lim_p;
    if (roll > lim_r) roll = lim_r;
    else if (roll < -lim_r) roll = -lim_r;
    // a zero pitch limit leaves pitch unscaled (it is already clamped to zero)
    if (lim_p > 0) pitch = (pitch * PITCH_SPAN) / lim_p;
    pitch = pitch - BAR_LIFT;

    // bar columns, division and remainder truncate toward zero
    for (x = -4; x <= 4; x++) begin
      y = (-roll * x) / 8 - pitch;
      if (y >= 0 && y <= BAR_TOP) begin
        run[n] = '{col: 8'(cc + x),
                   row: 7'(cr + y / ahg_pkg::SYMBOL_COUNT - ahg_pkg::SYMBOL_COUNT / 2),
                   code: 8'(reg_model.bar_symbol_base + y % ahg_pkg::SYMBOL_COUNT),
                   blink: blink, last: 1'b0};
        n++;
      end
    end

    // sidebar columns left then right per row, then the two markers
    if (reg_model.mode_flags[ahg_pkg::MODE_SIDEBARS]) begin
      for (y = -h; y <= h; y++) begin
        run[n]     = '{col: 8'(cc - w), row: 7'(cr + y),
                       code: ahg_pkg::DECORATION_SYMBOL, blink: blink, last: 1'b0};
        run[n + 1] = '{col: 8'(cc + w), row: 7'(cr + y),
                       code: ahg_pkg::DECORATION_SYMBOL, blink: blink, last: 1'b0};
        n += 2;
      end
      run[n]     = '{col: 8'(cc - w + 1), row: 7'(cr), code: ahg_pkg::LEFT_SYMBOL,
                     blink: blink, last: 1'b0};
      run[n + 1] = '{col: 8'(cc + w - 1), row: 7'(cr), code: ahg_pkg::RIGHT_SYMBOL,
                     blink: blink, last: 1'b0};
      n += 2;
    end

    // glyphs past the limit are dropped, the last one kept carries the flag
    cap = (n > GLYPH_LIMIT) ? GLYPH_LIMIT : n;
    for (i = 0; i < cap; i++) begin
      if (i == cap - 1) run[i].last = 1'b1;
      expected_glyphs.insert(expected_glyphs.size(), run[i]);
    end
  endfunction

  // check incoming glyphs against the oldest prediction
  always @(posedge clk) begin
    glyph_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_glyphs.size() == 0) begin
        $error("unexpected glyph: col %0d row %0d code %0d",
               out_glyph_col, out_glyph_row, out_glyph_code);
        glyph_errors++;
      end else begin
        want = expected_glyphs.pop_front();
        if (out_glyph_col !== want.col) begin
          $error("glyph_col: expected %0d, got %0d", $signed(want.col), out_glyph_col);
          glyph_errors++;
        end
        if (out_glyph_row !== want.row) begin
          $error("glyph_row: expected %0d, got %0d", $signed(want.row), out_glyph_row);
          glyph_errors++;
        end
        if (out_glyph_code !== want.code) begin
          $error("glyph_code: expected %0d, got %0d", want.code, out_glyph_code);
          glyph_errors++;
        end
        if (out_glyph_blink !== want.blink) begin
          $error("glyph_blink: expected %0d, got %0d", want.blink, out_glyph_blink);
          glyph_errors++;
        end
        if (out_last_glyph !== want.last) begin
          $error("last_glyph: expected %0d, got %0d", want.last, out_last_glyph);
          glyph_errors++;
        end
      end
    end
  end

  // hand one word over; start stays high if the next word follows at once
  task automatic send_word(logic [8:0] pitch, logic [8:0] roll, logic blink);
    int gap;
    gap = (idle_enable && $urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_pitch_deg <= pitch;
    in_roll_deg  <= roll;
    in_blink_on  <= blink;
    do @(posedge clk); while (busy);
    predict_glyphs(pitch, roll, blink);
  endtask

  // stop sending and let every predicted glyph come out, then let the block settle
  task automatic drain_glyphs();
    start <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; dirty sets random bits above the register's width
  task automatic write_reg(logic [3:0] index, logic [7:0] value, int width, bit dirty);
    logic [7:0] data;
    data = value;
    if (dirty) data = (8'($urandom) & ~((8'd1 << width) - 8'd1)) | value;
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      ahg_pkg::CFG_MODE_FLAGS:      reg_model.mode_flags      = data[2:0];
      ahg_pkg::CFG_MAX_PITCH:       reg_model.max_pitch       = data[6:0];
      ahg_pkg::CFG_MAX_ROLL:        reg_model.max_roll        = data[6:0];
      ahg_pkg::CFG_SIDEBAR_HEIGHT:  reg_model.sidebar_height  = data[3:0];
      ahg_pkg::CFG_SIDEBAR_WIDTH:   reg_model.sidebar_width   = data[3:0];
      ahg_pkg::CFG_CENTER_COL:      reg_model.center_col      = data[5:0];
      ahg_pkg::CFG_CENTER_ROW:      reg_model.center_row      = data[4:0];
      ahg_pkg::CFG_BAR_SYMBOL_BASE: reg_model.bar_symbol_base = data;
      default: ;
    endcase
  endtask

  // full register setting, only once the block has gone quiet
  task automatic write_cfg(ahg_pkg::cfg_t c, bit dirty);
    drain_glyphs();
    // a write to an unused index must leave every register alone
    if (dirty) write_reg(4'($urandom_range(15, CFG_STRAY_LO)), 8'($urandom), 8, 1'b0);
    write_reg(ahg_pkg::CFG_MODE_FLAGS,      8'(c.mode_flags),     3, dirty);
    write_reg(ahg_pkg::CFG_MAX_PITCH,       8'(c.max_pitch),      7, dirty);
    write_reg(ahg_pkg::CFG_MAX_ROLL,        8'(c.max_roll),       7, dirty);
    write_reg(ahg_pkg::CFG_SIDEBAR_HEIGHT,  8'(c.sidebar_height), 4, dirty);
    write_reg(ahg_pkg::CFG_SIDEBAR_WIDTH,   8'(c.sidebar_width),  4, dirty);
    write_reg(ahg_pkg::CFG_CENTER_COL,      8'(c.center_col),     6, dirty);
    write_reg(ahg_pkg::CFG_CENTER_ROW,      8'(c.center_row),     5, dirty);
    write_reg(ahg_pkg::CFG_BAR_SYMBOL_BASE, c.bar_symbol_base,    8, dirty);
    cfg_valid <= 1'b0;
  endtask

  // mostly in-range limits and short sidebars, now and then raw or tall ones
  function automatic ahg_pkg::cfg_t random_config();
    ahg_pkg::cfg_t c;
    c.mode_flags = 3'($urandom);
    c.max_pitch  = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 90));
    c.max_roll   = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 90));
    c.sidebar_height = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(6, 15))
                                                   : 4'($urandom_range(0, 4));
    c.sidebar_width   = 4'($urandom);
    c.center_col      = 6'($urandom);
    c.center_row      = 5'($urandom);
    c.bar_symbol_base = 8'($urandom);
    return c;
  endfunction

  // angles mostly near the clamp limits, a quarter over the full 9-bit range
  task automatic send_random_word();
    int lim_p, lim_r, p, r;
    lim_p = reg_model.max_pitch + 8;
    lim_r = reg_model.max_roll + 8;
    if ($urandom_range(0, 3) == 0) p = int'($urandom_range(0, 511)) - 256;
    else p = int'($urandom_range(0, 2 * lim_p)) - lim_p;
    if ($urandom_range(0, 3) == 0) r = int'($urandom_range(0, 511)) - 256;
    else r = int'($urandom_range(0, 2 * lim_r)) - lim_r;
    send_word(9'(p), 9'(r), 1'($urandom));
  endtask

  // reset settings: level, clamp edges and far beyond them
  task automatic test_reset_config();
    send_word(9'(0), 9'(0), 1'b0);
    send_word(9'(20), 9'(40), 1'b1);
    send_word(9'(-20), 9'(-40), 1'b0);
    send_word(9'(180), 9'(180), 1'b1);
    send_word(9'(-180), 9'(-180), 1'b0);
  endtask

  // pitch and roll inversion, alone and with sidebars
  task automatic test_inversion();
    ahg_pkg::cfg_t c;
    c = ahg_pkg::CFG_RESET;
    c.mode_flags[ahg_pkg::MODE_INV_PITCH] = 1'b1;
    c.mode_flags[ahg_pkg::MODE_INV_ROLL]  = 1'b1;
    write_cfg(c, 1'b0);
    send_word(9'(15), 9'(-30), 1'b1);
    send_word(9'(-15), 9'(30), 1'b0);
    c.mode_flags[ahg_pkg::MODE_SIDEBARS] = 1'b1;
    write_cfg(c, 1'b0);
    send_word(9'(10), 9'(10), 1'b1);
  endtask

  // widest limits, far corner of the grid, code base that wraps
  task automatic test_wide_limits();
    ahg_pkg::cfg_t c;
    c.mode_flags = '0;
    c.mode_flags[ahg_pkg::MODE_SIDEBARS] = 1'b1;
    c.max_pitch       = 7'd90;
    c.max_roll        = 7'd90;
    c.sidebar_height  = 4'd0;
    c.sidebar_width   = 4'd15;
    c.center_col      = 6'd63;
    c.center_row      = 5'd31;
    c.bar_symbol_base = 8'd255;
    write_cfg(c, 1'b0);
    send_word(9'(90), 9'(90), 1'b1);
    send_word(9'(-90), 9'(-90), 1'b0);
    send_word(9'(0), 9'(45), 1'b1);
  endtask

  // zero limits: pitch scaling skipped, columns left of the grid wrap
  task automatic test_zero_limits();
    ahg_pkg::cfg_t c;
    c = '0;
    c.mode_flags[ahg_pkg::MODE_SIDEBARS] = 1'b1;
    write_cfg(c, 1'b0);
    send_word(9'(100), 9'(-100), 1'b1);
    send_word(9'(0), 9'(0), 1'b0);
  endtask

  // tall sidebars overflow the glyph cap; raw limits and 9-bit angle extremes
  task automatic test_glyph_cap();
    ahg_pkg::cfg_t c;
    c = ahg_pkg::CFG_RESET;
    c.mode_flags[ahg_pkg::MODE_SIDEBARS] = 1'b1;
    c.sidebar_height = 4'd12;
    write_cfg(c, 1'b0);
    send_word(9'(0), 9'(0), 1'b1);
    send_word(9'(5), 9'(-5), 1'b0);
    c.max_pitch      = 7'd127;
    c.max_roll       = 7'd127;
    c.sidebar_height = 4'd15;
    write_cfg(c, 1'b1);
    send_word(9'h100, 9'h0FF, 1'b1);
    send_word(9'h0FF, 9'h100, 1'b0);
  endtask

  // random phases, one setting each; the last phase sends back to back
  task automatic test_random_phases();
    int phase, k;
    for (phase = 0; phase < PHASES; phase++) begin
      idle_enable = (phase < PHASES - 1);
      write_cfg(random_config(), phase % 2 == 1);
      for (k = 0; k < PHASE_WORDS; k++) begin
        // hold the sender until the output side has caught up
        if (phase == 2 && k == PHASE_WORDS / 2) drain_glyphs();
        send_random_word();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_inversion();
    test_wide_limits();
    test_zero_limits();
    test_glyph_cap();
    test_random_phases();
    drain_glyphs();
    if (glyph_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
